// ----- design/change_report_event_scheduler_unit_macros.svh -----
// Assertion macros shared by the scheduler's checker.
`ifndef CHANGE_REPORT_EVENT_SCHEDULER_UNIT_MACROS_SVH
`define CHANGE_REPORT_EVENT_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CRES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cres_pkg.sv -----
// Types and constants of the change report event scheduler.
`default_nettype none

package cres_pkg;

  localparam int COUNTER_FIELD_BITS   = 32;
  localparam int COUNTER_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_BITS       = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GAP       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEACON_PERIOD = 2'd1;

  localparam logic [31:0] MIN_GAP_RESET       = 32'd100;
  localparam logic [31:0] BEACON_PERIOD_RESET = 32'd1000;

  localparam logic [2:0] KIND_BEACON   = 3'd0;
  localparam logic [2:0] KIND_RX       = 3'd1;
  localparam logic [2:0] KIND_PARSER   = 3'd2;
  localparam logic [2:0] KIND_TX       = 3'd3;
  localparam logic [2:0] KIND_QUEUE    = 3'd4;
  localparam int         KIND_COUNT    = 5;

  typedef struct packed {
    logic [31:0]        now_time_ms;
    logic [31:0]        rx_byte_total;
    logic [31:0]        rx_frame_total;
    logic [31:0]        parse_error_total;
    logic [31:0]        hello_total;
    logic [7:0]         parse_state_code;
    logic [7:0]         hello_outcome_code;
    logic [31:0]        write_asked_len;
    logic signed [31:0] write_outcome;
    logic [31:0]        frames_made_total;
    logic [31:0]        frames_dropped_total;
    logic [31:0]        frames_waiting;
  } in_item_t;

  typedef struct packed {
    logic       emitted;
    logic [2:0] event_kind;
  } out_item_t;

  typedef struct packed {
    logic [31:0] min_gap_ms;
    logic [31:0] beacon_period_ms;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ----- design/cres_in_stage.sv -----
// Input register of the scheduler.
`default_nettype none

module cres_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cres_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              item_valid,
  output cres_pkg::in_item_t item
);
  import cres_pkg::*;

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/cres_core.sv -----
// Event decision logic and reported-state registers.
`default_nettype none

module cres_core #(
  parameter int COUNTER_BITS = cres_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cres_pkg::cfg_regs_t  cfg,
  input  logic                fire,
  input  cres_pkg::in_item_t   item,
  output cres_pkg::out_item_t  result
);
  import cres_pkg::*;

  localparam int CMP_BITS =
    (COUNTER_BITS < COUNTER_FIELD_BITS) ? COUNTER_BITS : COUNTER_FIELD_BITS;

  logic [31:0]           last_event_time;
  logic [31:0]           last_beacon_time;
  logic [KIND_COUNT-1:0] reported_mask;
  logic                  any_event_sent;
  logic                  first_beacon_due;

  logic [CMP_BITS-1:0] seen_rx0, seen_rx1;
  logic [CMP_BITS-1:0] seen_pc0, seen_pc1;
  logic [7:0]          seen_code0, seen_code1;
  logic [31:0]         seen_wr0, seen_wr1;
  logic [CMP_BITS-1:0] seen_q0, seen_q1, seen_q2;

  logic [31:0] event_age;
  logic [31:0] beacon_age;
  logic        gap_ok;
  logic        beacon_ok;
  logic        rx_chg;
  logic        ps_chg;
  logic        wr_chg;
  logic        q_chg;
  logic        emit;
  logic [2:0]  kind;
  logic        commit;

  assign event_age  = item.now_time_ms - last_event_time;
  assign beacon_age = item.now_time_ms - last_beacon_time;
  assign gap_ok     = !any_event_sent || (event_age >= cfg.min_gap_ms);
  assign beacon_ok  = beacon_age >= cfg.beacon_period_ms;

  assign rx_chg = !reported_mask[KIND_RX] ||
                  (item.rx_byte_total[CMP_BITS-1:0] != seen_rx0) ||
                  (item.rx_frame_total[CMP_BITS-1:0] != seen_rx1);
  assign ps_chg = !reported_mask[KIND_PARSER] ||
                  (item.parse_error_total[CMP_BITS-1:0] != seen_pc0) ||
                  (item.hello_total[CMP_BITS-1:0] != seen_pc1) ||
                  (item.parse_state_code != seen_code0) ||
                  (item.hello_outcome_code != seen_code1);
  assign wr_chg = !reported_mask[KIND_TX] ||
                  (item.write_asked_len != seen_wr0) ||
                  (item.write_outcome != seen_wr1);
  assign q_chg  = !reported_mask[KIND_QUEUE] ||
                  (item.frames_made_total[CMP_BITS-1:0] != seen_q0) ||
                  (item.frames_dropped_total[CMP_BITS-1:0] != seen_q1) ||
                  (item.frames_waiting[CMP_BITS-1:0] != seen_q2);

  always_comb begin
    emit = 1'b0;
    kind = KIND_BEACON;
    if (gap_ok) begin
      if (first_beacon_due) begin
        emit = 1'b1;
      end else if (rx_chg) begin
        emit = 1'b1;
        kind = KIND_RX;
      end else if (ps_chg) begin
        emit = 1'b1;
        kind = KIND_PARSER;
      end else if (wr_chg) begin
        emit = 1'b1;
        kind = KIND_TX;
      end else if (q_chg) begin
        emit = 1'b1;
        kind = KIND_QUEUE;
      end else if (beacon_ok) begin
        emit = 1'b1;
      end
    end
  end

  assign result.emitted    = emit;
  assign result.event_kind = kind;
  assign commit            = fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_event_time  <= '0;
      last_beacon_time <= '0;
      reported_mask    <= '0;
      any_event_sent   <= 1'b0;
      first_beacon_due <= 1'b1;
    end else if (commit) begin
      reported_mask    <= reported_mask | (KIND_COUNT'(1) << kind);
      last_event_time  <= item.now_time_ms;
      any_event_sent   <= 1'b1;
      first_beacon_due <= 1'b0;
      if (kind == KIND_BEACON) begin
        last_beacon_time <= item.now_time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && kind == KIND_RX) begin
      seen_rx0 <= item.rx_byte_total[CMP_BITS-1:0];
      seen_rx1 <= item.rx_frame_total[CMP_BITS-1:0];
    end
    if (commit && kind == KIND_PARSER) begin
      seen_pc0   <= item.parse_error_total[CMP_BITS-1:0];
      seen_pc1   <= item.hello_total[CMP_BITS-1:0];
      seen_code0 <= item.parse_state_code;
      seen_code1 <= item.hello_outcome_code;
    end
    if (commit && kind == KIND_TX) begin
      seen_wr0 <= item.write_asked_len;
      seen_wr1 <= item.write_outcome;
    end
    if (commit && kind == KIND_QUEUE) begin
      seen_q0 <= item.frames_made_total[CMP_BITS-1:0];
      seen_q1 <= item.frames_dropped_total[CMP_BITS-1:0];
      seen_q2 <= item.frames_waiting[CMP_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/change_report_event_scheduler_unit.sv -----
// Change report event scheduler: top level with config registers and result register.
//
// One snapshot beat on the input channel (in_valid/in_stall/in_data) gives one
// result beat on the output channel (out_valid/out_stall/out_data): emitted
// tells whether a diagnostic event goes out now, event_kind which one.
// A snapshot passes through the input register, which takes it at the accept edge,
// and then the result register, which takes its decision once the output does not stall.
// Throughput is one snapshot per cycle while the output does not stall; the 32-bit
// wrap-around age compares and field compares on the reported copies sit in between.
// The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 sets min_gap_ms, index 1 sets beacon_period_ms, other
// indexes are ignored. Write it only while no snapshot is in flight.
// A stall on the output holds the result register; the input register then
// fills and in_stall rises, so nothing is lost or repeated.
// Synchronous reset clears both valids, restores the register defaults
// (100 ms gap, 1000 ms beacon period) and arms the first beacon.
`default_nettype none

module change_report_event_scheduler_unit #(
  parameter int COUNTER_BITS = cres_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  cres_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output cres_pkg::out_item_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cres_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [31:0]                           cfg_data
);
  import cres_pkg::*;

  cfg_regs_t cfg;
  logic      advance;
  logic      item_valid;
  in_item_t  item;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_gap_ms       <= MIN_GAP_RESET;
      cfg.beacon_period_ms <= BEACON_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_GAP:       cfg.min_gap_ms       <= cfg_data;
        REG_BEACON_PERIOD: cfg.beacon_period_ms <= cfg_data;
        default:           ;
      endcase
    end
  end

  cres_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cres_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (item_valid && advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- design/cres_checker.sv -----
// Port-level checker for the change report event scheduler, with its bind.
`include "change_report_event_scheduler_unit_macros.svh"
`default_nettype none

module cres_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cres_pkg::out_item_t out_data
);
  import cres_pkg::*;

  `CRES_ASSERT_NOW(a_quiet_kind, clk, rst,
    out_valid && !out_data.emitted, out_data.event_kind == KIND_BEACON,
    "no-event beat carries nonzero kind")
  `CRES_ASSERT_NOW(a_kind_range, clk, rst,
    out_valid, out_data.event_kind <= KIND_QUEUE,
    "event kind out of range")
  `CRES_ASSERT_NEXT(a_out_hold, clk, rst,
    out_valid && out_stall, out_valid && $stable(out_data),
    "stalled result beat changed")
  `CRES_ASSERT_NEXT(a_backpressure, clk, rst,
    in_valid && in_stall, out_valid && $past(out_stall),
    "input stalled without output stall")

endmodule

bind change_report_event_scheduler_unit cres_checker u_cres_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench: random and directed snapshots against a built-in event predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cres_pkg::*;

  localparam int CNT_W = COUNTER_BITS_DEFAULT;
  localparam logic [31:0] CNT_KEEP = (CNT_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << CNT_W) - 1);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PULSE} stall_mode_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_item_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [31:0]               cfg_data;

  change_report_event_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Scheduler state mirror
  logic [31:0]           gap_ms_r;
  logic [31:0]           beacon_ms_r;
  logic [31:0]           last_evt_ms;
  logic [31:0]           last_bcn_ms;
  logic [KIND_COUNT-1:0] reported;
  bit                    sent_any;
  bit                    first_due;
  logic [31:0]           rx_seen [2];
  logic [31:0]           pc_seen [2];
  logic [7:0]            code_seen [2];
  logic [31:0]           wr_seen [2];
  logic [31:0]           q_seen [3];

  out_item_t   kind_q [$];
  int          errors = 0;
  int          burst_left = 0;
  in_item_t    snap;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_tick = 0;

  function automatic bit span_elapsed(logic [31:0] now, logic [31:0] then, logic [31:0] span);
    logic [31:0] age;
    age = now - then;
    return age >= span;
  endfunction

  function automatic out_item_t predict_event(in_item_t s);
    out_item_t   r;
    logic [2:0]  kind;
    logic [31:0] rx0, rx1, pc0, pc1, q0, q1, q2;
    r = '0;
    kind = KIND_BEACON;
    rx0 = s.rx_byte_total & CNT_KEEP;
    rx1 = s.rx_frame_total & CNT_KEEP;
    pc0 = s.parse_error_total & CNT_KEEP;
    pc1 = s.hello_total & CNT_KEEP;
    q0 = s.frames_made_total & CNT_KEEP;
    q1 = s.frames_dropped_total & CNT_KEEP;
    q2 = s.frames_waiting & CNT_KEEP;
    if (sent_any && !span_elapsed(s.now_time_ms, last_evt_ms, gap_ms_r))
      return r;
    if (first_due) begin
      first_due = 1'b0;
    end else if (!reported[KIND_RX] || rx0 != rx_seen[0] || rx1 != rx_seen[1]) begin
      kind = KIND_RX;
      rx_seen[0] = rx0;
      rx_seen[1] = rx1;
    end else if (!reported[KIND_PARSER] || pc0 != pc_seen[0] || pc1 != pc_seen[1] ||
                 s.parse_state_code != code_seen[0] ||
                 s.hello_outcome_code != code_seen[1]) begin
      kind = KIND_PARSER;
      pc_seen[0] = pc0;
      pc_seen[1] = pc1;
      code_seen[0] = s.parse_state_code;
      code_seen[1] = s.hello_outcome_code;
    end else if (!reported[KIND_TX] || s.write_asked_len != wr_seen[0] ||
                 s.write_outcome != wr_seen[1]) begin
      kind = KIND_TX;
      wr_seen[0] = s.write_asked_len;
      wr_seen[1] = s.write_outcome;
    end else if (!reported[KIND_QUEUE] || q0 != q_seen[0] || q1 != q_seen[1] ||
                 q2 != q_seen[2]) begin
      kind = KIND_QUEUE;
      q_seen[0] = q0;
      q_seen[1] = q1;
      q_seen[2] = q2;
    end else if (!span_elapsed(s.now_time_ms, last_bcn_ms, beacon_ms_r)) begin
      return r;
    end
    reported[kind] = 1'b1;
    last_evt_ms = s.now_time_ms;
    sent_any = 1'b1;
    if (kind == KIND_BEACON)
      last_bcn_ms = s.now_time_ms;
    r.emitted = 1'b1;
    r.event_kind = kind;
    return r;
  endfunction

  task automatic send_snapshot(input in_item_t item);
    int idle_cycles;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      idle_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (idle_cycles) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    kind_q.push_back(predict_event(item));
  endtask

  task automatic send_at(input logic [31:0] t);
    snap.now_time_ms = t;
    send_snapshot(snap);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (kind_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_GAP:       gap_ms_r = val;
      REG_BEACON_PERIOD: beacon_ms_r = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] gap, input logic [31:0] period);
    write_reg(REG_MIN_GAP, gap);
    write_reg(REG_BEACON_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  task automatic next_snapshot();
    int pick;
    int i;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      snap.now_time_ms += $urandom_range(0, 25);
    else if (pick < 70)
      snap.now_time_ms += $urandom_range(0, 400);
    else if (pick < 80)
      snap.now_time_ms = last_evt_ms + gap_ms_r - $urandom_range(0, 1);
    else if (pick < 90)
      snap.now_time_ms = last_bcn_ms + beacon_ms_r - $urandom_range(0, 1);
    else
      snap.now_time_ms = $urandom();
    if ($urandom_range(0, 49) == 0) begin
      for (i = 0; i < $bits(in_item_t); i += 16)
        snap[i +: 16] = 16'($urandom());
      return;
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: snap.rx_byte_total += $urandom_range(1, 64);
        1: snap.rx_frame_total += 1;
        default: begin
          snap.rx_byte_total = $urandom();
          snap.rx_frame_total = $urandom();
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: snap.parse_error_total += 1;
        1: snap.hello_total += 1;
        2: snap.parse_state_code = 8'($urandom());
        default: snap.hello_outcome_code = 8'($urandom());
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: snap.write_asked_len = $urandom_range(0, 4096);
        1: snap.write_outcome = -$signed(32'($urandom_range(1, 20)));
        default: snap.write_outcome = $urandom();
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: snap.frames_made_total += 1;
        1: snap.frames_dropped_total += 1;
        2: snap.frames_waiting = $urandom_range(0, 8);
        default: begin
          snap.frames_made_total = $urandom();
          snap.frames_dropped_total = $urandom();
          snap.frames_waiting = $urandom();
        end
      endcase
    end
  endtask

  task automatic test_opening_sequence();
    snap = '0;
    send_at(0);
    send_at(50);
    send_at(100);
    send_at(199);
    send_at(200);
    send_at(300);
    send_at(400);
    send_at(500);
    send_at(999);
    send_at(1000);
  endtask

  task automatic test_field_extremes();
    snap.rx_byte_total = '1;
    snap.rx_frame_total = '1;
    send_at(1100);
    snap.parse_error_total = '1;
    snap.hello_total = '1;
    snap.parse_state_code = '1;
    snap.hello_outcome_code = '1;
    send_at(1200);
    snap.write_asked_len = '1;
    snap.write_outcome = 32'sh8000_0000;
    send_at(1300);
    snap.frames_made_total = '1;
    snap.frames_dropped_total = '1;
    snap.frames_waiting = '1;
    send_at(1400);
    snap.write_outcome = -32'sd1;
    send_at(1500);
  endtask

  task automatic test_time_wrap();
    send_at(32'hFFFF_FF00);
    send_at(32'h0000_0010);
    snap.rx_byte_total = '0;
    send_at(5);
    snap.hello_outcome_code = 8'h5A;
    send_at(3);
  endtask

  task automatic test_zero_gap_period();
    drain();
    write_reg(REG_MIN_GAP, '0);
    write_reg(REG_BEACON_PERIOD, '0);
    write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
    send_at(3);
    send_at(3);
    snap.frames_waiting = 7;
    send_at(3);
  endtask

  task automatic test_max_gap_period();
    drain();
    configure('1, '1);
    send_at(100);
    send_at(2);
  endtask

  task automatic test_random_phase(input logic [31:0] gap, input logic [31:0] period,
                                   input int count);
    drain();
    configure(gap, period);
    repeat (count) begin
      next_snapshot();
      send_snapshot(snap);
    end
  endtask

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 300);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (kind_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat emitted=%0b kind=%0d", $time,
                 out_data.emitted, out_data.event_kind);
      end else begin
        want = kind_q.pop_front();
        if (out_data.emitted !== want.emitted) begin
          errors++;
          $display("%0t: emitted expected %0b actual %0b", $time,
                   want.emitted, out_data.emitted);
        end
        if (out_data.event_kind !== want.event_kind) begin
          errors++;
          $display("%0t: event_kind expected %0d actual %0d", $time,
                   want.event_kind, out_data.event_kind);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_ms_r = MIN_GAP_RESET;
    beacon_ms_r = BEACON_PERIOD_RESET;
    last_evt_ms = '0;
    last_bcn_ms = '0;
    reported = '0;
    sent_any = 1'b0;
    first_due = 1'b1;
    rx_seen = '{default: '0};
    pc_seen = '{default: '0};
    code_seen = '{default: '0};
    wr_seen = '{default: '0};
    q_seen = '{default: '0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_opening_sequence();
    test_field_extremes();
    test_time_wrap();
    test_zero_gap_period();
    test_max_gap_period();
    test_random_phase(MIN_GAP_RESET, BEACON_PERIOD_RESET, 500);
    test_random_phase('0, '0, 200);
    test_random_phase(32'd5, 32'd40, 400);
    test_random_phase('1, '1, 150);
    test_random_phase($urandom_range(1, 300), $urandom_range(1, 3000), 450);
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
